@@ sv/rpl_pkg.sv @@
`default_nettype none

package rpl_pkg;

  localparam int CFG_DATA_W       = 16;
  localparam int CFG_INDEX_W      = 8;
  localparam int FIELD_W          = 16;
  localparam int INDEX_BITS_DEF   = 16;
  localparam int SAMPLE_BITS_DEF  = 16;

  // 0.6 s at 360 samples/s
  localparam logic [CFG_DATA_W-1:0] MIN_SEP_RESET    = 16'd216;
  localparam logic [CFG_DATA_W-1:0] PEAK_LIMIT_RESET = 16'd10;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MIN_SEPARATION = 8'd0,
    REG_PEAK_LIMIT     = 8'd1
  } reg_index_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] min_separation;
    logic [CFG_DATA_W-1:0] peak_limit;
  } cfg_t;

endpackage

`default_nettype wire

@@ sv/rpl_if.sv @@
`default_nettype none

interface rpl_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          edge_marker;
  logic                          last_sample;

  modport source (output valid, sample, edge_marker, last_sample, input ready);
  modport sink   (input valid, sample, edge_marker, last_sample, output ready);
endinterface

interface rpl_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] peak_position;
  logic [15:0] peak_number;

  modport source (output valid, peak_position, peak_number, input ready);
  modport sink   (input valid, peak_position, peak_number, output ready);
endinterface

`default_nettype wire

@@ sv/rpl_cfg.sv @@
`default_nettype none

module rpl_cfg
  import rpl_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_separation <= MIN_SEP_RESET;
      cfg.peak_limit     <= PEAK_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_SEPARATION: cfg.min_separation <= cfg_data;
        REG_PEAK_LIMIT:     cfg.peak_limit     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sv/rpl_tracker.sv @@
`default_nettype none

module rpl_tracker
  import rpl_pkg::*;
#(
  parameter int INDEX_BITS  = INDEX_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          step,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  input  wire logic                          edge_marker,
  input  wire logic                          last_sample,
  input  wire cfg_t                          cfg,
  output logic                               emit,
  output logic [FIELD_W-1:0]                 peak_position,
  output logic [FIELD_W-1:0]                 peak_number
);

  localparam int CMP_W = (INDEX_BITS > CFG_DATA_W) ? INDEX_BITS : CFG_DATA_W;

  logic [INDEX_BITS-1:0]  sample_counter, sample_counter_next;
  logic                   complex_open, complex_open_next;
  logic [INDEX_BITS-1:0]  complex_start, complex_start_next;
  logic [INDEX_BITS-1:0]  complex_end, complex_end_next;
  logic [SAMPLE_BITS-1:0] committed_max, committed_max_next;
  logic [INDEX_BITS-1:0]  committed_index, committed_index_next;
  logic [SAMPLE_BITS-1:0] pending_max, pending_max_next;
  logic [INDEX_BITS-1:0]  pending_index, pending_index_next;
  logic [FIELD_W-1:0]     peaks_found, peaks_found_next;
  logic                   halted, halted_next;

  logic [SAMPLE_BITS-1:0] mag;
  logic [INDEX_BITS-1:0]  marker_gap;
  logic [INDEX_BITS-1:0]  pos;
  logic                   under_limit;
  logic                   far;

  // true absolute value; most negative code maps to 2^(SAMPLE_BITS-1)
  assign mag = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
  assign marker_gap = sample_counter - complex_end;
  assign far = CMP_W'(marker_gap) >= CMP_W'(cfg.min_separation);
  assign under_limit = peaks_found < cfg.peak_limit;

  always_comb begin
    sample_counter_next  = sample_counter;
    complex_open_next    = complex_open;
    complex_start_next   = complex_start;
    complex_end_next     = complex_end;
    committed_max_next   = committed_max;
    committed_index_next = committed_index;
    pending_max_next     = pending_max;
    pending_index_next   = pending_index;
    peaks_found_next     = peaks_found;
    halted_next          = halted;
    emit                 = 1'b0;
    pos                  = committed_index;

    if (!halted) begin
      if (edge_marker) begin
        if (!complex_open || (far && under_limit)) begin
          if (complex_open) begin
            emit             = 1'b1;
            peaks_found_next = peaks_found + 1'b1;
          end
          complex_open_next    = 1'b1;
          complex_start_next   = sample_counter;
          complex_end_next     = sample_counter;
          committed_max_next   = '0;
          committed_index_next = sample_counter;
          pending_max_next     = mag;
          pending_index_next   = sample_counter;
        end else if (far) begin
          halted_next = 1'b1;
        end else begin
          if (pending_max > committed_max) begin
            committed_max_next   = pending_max;
            committed_index_next = pending_index;
          end
          complex_end_next   = sample_counter;
          pending_max_next   = mag;
          pending_index_next = sample_counter;
        end
      end else if (complex_open && mag > pending_max) begin
        pending_max_next   = mag;
        pending_index_next = sample_counter;
      end
    end

    if (last_sample) begin
      // flush a complex holding at least two markers
      if (!halted_next && complex_open_next && complex_end_next != complex_start_next &&
          under_limit && !emit) begin
        emit = 1'b1;
        pos  = committed_index_next;
      end
      sample_counter_next  = '0;
      complex_open_next    = 1'b0;
      complex_start_next   = '0;
      complex_end_next     = '0;
      committed_max_next   = '0;
      committed_index_next = '0;
      pending_max_next     = '0;
      pending_index_next   = '0;
      peaks_found_next     = '0;
      halted_next          = 1'b0;
    end else begin
      sample_counter_next = sample_counter + 1'b1;
    end
  end

  always_comb begin
    peak_number = peaks_found;
    if (INDEX_BITS >= FIELD_W) begin
      peak_position = pos[FIELD_W-1:0];
    end else begin
      peak_position = FIELD_W'(pos);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_counter  <= '0;
      complex_open    <= 1'b0;
      complex_start   <= '0;
      complex_end     <= '0;
      committed_max   <= '0;
      committed_index <= '0;
      pending_max     <= '0;
      pending_index   <= '0;
      peaks_found     <= '0;
      halted          <= 1'b0;
    end else if (step) begin
      sample_counter  <= sample_counter_next;
      complex_open    <= complex_open_next;
      complex_start   <= complex_start_next;
      complex_end     <= complex_end_next;
      committed_max   <= committed_max_next;
      committed_index <= committed_index_next;
      pending_max     <= pending_max_next;
      pending_index   <= pending_index_next;
      peaks_found     <= peaks_found_next;
      halted          <= halted_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/ecg_r_peak_locator.sv @@
// R-peak locator for a stream of filtered ECG samples. One sample word is
// taken per clock, as the single state update loop allows, unless a stalled
// result register holds the pipeline; each word passes an input register,
// compare and update logic against the running complex state, and a result
// register, which takes the peak word for the sample that closes or flushes
// its complex. min_separation and peak_limit are to be written by the user
// only while the stream is idle; the block itself does not enforce this.
`default_nettype none

module ecg_r_peak_locator
  import rpl_pkg::*;
#(
  parameter int INDEX_BITS  = INDEX_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  rpl_in_if.sink                      samples,
  rpl_out_if.source                   peaks
);

  cfg_t cfg;

  logic                          in_valid;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic                          in_marker;
  logic                          in_last;
  logic                          advance;

  logic               emit;
  logic [FIELD_W-1:0] peak_position;
  logic [FIELD_W-1:0] peak_number;

  logic               out_valid;
  logic [FIELD_W-1:0] out_position;
  logic [FIELD_W-1:0] out_number;

  assign advance       = in_valid && (!out_valid || peaks.ready);
  assign samples.ready = !in_valid || advance;

  rpl_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (samples.ready) begin
      in_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      in_sample <= samples.sample;
      in_marker <= samples.edge_marker;
      in_last   <= samples.last_sample;
    end
  end

  rpl_tracker #(
    .INDEX_BITS  (INDEX_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_tracker (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .sample        (in_sample),
    .edge_marker   (in_marker),
    .last_sample   (in_last),
    .cfg           (cfg),
    .emit          (emit),
    .peak_position (peak_position),
    .peak_number   (peak_number)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit;
    end else if (peaks.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_position <= peak_position;
      out_number   <= peak_number;
    end
  end

  assign peaks.valid         = out_valid;
  assign peaks.peak_position = out_position;
  assign peaks.peak_number   = out_number;

endmodule

`default_nettype wire

@@ dv/r_peak_compare.sv @@
`default_nettype none

module r_peak_compare
  import rpl_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  rpl_in_if                           samples,
  rpl_out_if                          peaks,
  output int                          mismatches,
  output int                          awaited,
  output int                          matched
);

  typedef struct packed {
    logic [15:0] position;
    logic [15:0] number;
  } peak_t;

  peak_t expected_peaks[$];
  cfg_t  cfg;
  int    fail_total;
  int    match_total;

  logic [15:0] idx_count;
  logic [15:0] open_start;
  logic [15:0] open_end;
  logic [15:0] best_mag;
  logic [15:0] best_pos;
  logic [15:0] run_mag;
  logic [15:0] run_pos;
  logic [15:0] peak_count;
  logic        in_complex;
  logic        stopped;

  task automatic clear_locator();
    idx_count  = '0;
    open_start = '0;
    open_end   = '0;
    best_mag   = '0;
    best_pos   = '0;
    run_mag    = '0;
    run_pos    = '0;
    peak_count = '0;
    in_complex = 1'b0;
    stopped    = 1'b0;
  endtask

  task automatic start_complex(input logic [15:0] here, input logic [15:0] mag);
    in_complex = 1'b1;
    open_start = here;
    open_end   = here;
    best_mag   = '0;
    best_pos   = here;
    run_mag    = mag;
    run_pos    = here;
  endtask

  task automatic report(input logic [15:0] pos);
    peak_t p;
    p.position = pos;
    p.number   = peak_count;
    expected_peaks.push_back(p);
    peak_count = peak_count + 16'd1;
  endtask

  task automatic take_sample(input logic [15:0] raw, input logic mk, input logic lst);
    logic [15:0] here;
    logic [15:0] mag;
    logic        produced;
    here     = idx_count;
    mag      = raw[15] ? (~raw + 16'd1) : raw;
    produced = 1'b0;
    if (!stopped) begin
      if (mk) begin
        if (!in_complex) begin
          start_complex(here, mag);
        end else if (16'(here - open_end) >= cfg.min_separation) begin
          if (peak_count < cfg.peak_limit) begin
            report(best_pos);
            produced = 1'b1;
            start_complex(here, mag);
          end else begin
            stopped = 1'b1;
          end
        end else begin
          if (run_mag > best_mag) begin
            best_mag = run_mag;
            best_pos = run_pos;
          end
          open_end = here;
          run_mag  = mag;
          run_pos  = here;
        end
      end else if (in_complex && mag > run_mag) begin
        run_mag = mag;
        run_pos = here;
      end
    end
    if (lst) begin
      if (!stopped && in_complex && open_end != open_start &&
          peak_count < cfg.peak_limit && !produced) begin
        report(best_pos);
      end
      clear_locator();
    end else begin
      idx_count = idx_count + 16'd1;
    end
  endtask

  task automatic check_peak(input logic [15:0] pos, input logic [15:0] num);
    peak_t want;
    if (expected_peaks.size() == 0) begin
      $error("unexpected peak word: peak_position %0d peak_number %0d", pos, num);
      fail_total++;
    end else begin
      want = expected_peaks.pop_front();
      if (pos !== want.position) begin
        $error("peak_position: expected %0d, got %0d", want.position, pos);
        fail_total++;
      end
      if (num !== want.number) begin
        $error("peak_number: expected %0d, got %0d", want.number, num);
        fail_total++;
      end
      if (pos === want.position && num === want.number) match_total++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_locator();
      cfg.min_separation = MIN_SEP_RESET;
      cfg.peak_limit     = PEAK_LIMIT_RESET;
      expected_peaks.delete();
      fail_total  = 0;
      match_total = 0;
    end else begin
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_MIN_SEPARATION: cfg.min_separation = cfg_data;
          REG_PEAK_LIMIT:     cfg.peak_limit     = cfg_data;
          default: ;
        endcase
      end
      if (samples.valid && samples.ready) begin
        take_sample(samples.sample, samples.edge_marker, samples.last_sample);
      end
      if (peaks.valid && peaks.ready) begin
        check_peak(peaks.peak_position, peaks.peak_number);
      end
    end
    mismatches <= fail_total;
    awaited    <= expected_peaks.size();
    matched    <= match_total;
  end

endmodule

`default_nettype wire

@@ dv/ecg_r_peak_locator_test.sv @@
`default_nettype none

module ecg_r_peak_locator_test;
  import rpl_pkg::*;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int mismatches;
  int awaited;
  int matched;

  int send_gap_pct;
  int stall_pct;
  int words_sent;
  int records_done;

  rpl_in_if #(.SAMPLE_BITS(16)) samples();
  rpl_out_if                    peaks();

  ecg_r_peak_locator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (samples),
    .peaks     (peaks)
  );

  r_peak_compare compare (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .samples    (samples),
    .peaks      (peaks),
    .mismatches (mismatches),
    .awaited    (awaited),
    .matched    (matched)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    peaks.ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [15:0] pick_sample();
    logic [15:0] v;
    case ($urandom_range(7))
      0, 1: v = 16'h0000;
      2: begin
        case ($urandom_range(4))
          0: v = 16'h8000;
          1: v = 16'h7FFF;
          2: v = 16'h8001;
          3: v = 16'h0001;
          default: v = 16'hFFFF;
        endcase
      end
      3: v = 16'($signed($urandom_range(32)) - 16);
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  task automatic configure(input logic [15:0] sep, input logic [15:0] lim);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MIN_SEPARATION;
    cfg_data  <= sep;
    @(posedge clk);
    cfg_index <= REG_PEAK_LIMIT;
    cfg_data  <= lim;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic push_word(input logic [15:0] s, input logic mk, input logic lst);
    while ($urandom_range(99) < send_gap_pct) begin
      samples.valid <= 1'b0;
      @(posedge clk);
    end
    samples.valid       <= 1'b1;
    samples.sample      <= s;
    samples.edge_marker <= mk;
    samples.last_sample <= lst;
    do @(posedge clk); while (!samples.ready);
    words_sent++;
    if (lst) records_done++;
  endtask

  // hold the input low until every predicted peak word is out, then let
  // the pipeline empty
  task automatic drain();
    samples.valid <= 1'b0;
    do @(posedge clk); while (awaited != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic send_record(input int len, input int marker_pct);
    for (int i = 0; i < len; i++) begin
      push_word(pick_sample(), $urandom_range(99) < marker_pct, i == len - 1);
    end
  endtask

  task automatic run_segment(input logic [15:0] sep, input logic [15:0] lim);
    int sent_here;
    int len;
    configure(sep, lim);
    sent_here = 0;
    while (sent_here < 60) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(50, 90) : $urandom_range(1, 40);
      case ($urandom_range(9))
        0: send_record(len, 0);
        1: send_record(len, 90);
        default: send_record(len, $urandom_range(10, 50));
      endcase
      sent_here += len;
      if (sent_here == len) drain();
    end
    drain();
  endtask

  initial begin
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    samples.valid       = 1'b0;
    samples.sample      = '0;
    samples.edge_marker = 1'b0;
    samples.last_sample = 1'b0;
    send_gap_pct        = 14;
    stall_pct           = 61;
    words_sent          = 0;
    records_done        = 0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: ties, zero spans, full-scale magnitudes, halt, flushes
    configure(16'd3, 16'd2);
    push_word(16'h0000, 1'b1, 1'b0);
    push_word(16'h0000, 1'b1, 1'b0);
    push_word(16'h0000, 1'b0, 1'b0);
    push_word(16'hFFFB, 1'b0, 1'b0);
    push_word(16'h0005, 1'b1, 1'b0);
    push_word(16'hFFFB, 1'b0, 1'b0);
    push_word(16'h0005, 1'b1, 1'b0);
    push_word(16'h8000, 1'b0, 1'b0);
    push_word(16'h7FFF, 1'b1, 1'b0);
    push_word(16'h0000, 1'b0, 1'b0);
    push_word(16'h0000, 1'b1, 1'b0);
    push_word(16'h0000, 1'b0, 1'b0);
    push_word(16'h0001, 1'b0, 1'b0);
    push_word(16'h0002, 1'b1, 1'b0);
    push_word(16'h0000, 1'b0, 1'b0);
    push_word(16'h0000, 1'b0, 1'b0);
    push_word(16'h0003, 1'b1, 1'b0);
    push_word(16'h0009, 1'b1, 1'b0);
    push_word(16'h0001, 1'b0, 1'b1);
    push_word(16'h0003, 1'b1, 1'b0);
    push_word(16'h0004, 1'b0, 1'b1);
    push_word(16'h8000, 1'b1, 1'b0);
    push_word(16'h7FFF, 1'b1, 1'b0);
    push_word(16'h0001, 1'b1, 1'b1);
    push_word(16'h0001, 1'b1, 1'b0);
    push_word(16'h0001, 1'b0, 1'b0);
    push_word(16'h0002, 1'b0, 1'b0);
    push_word(16'h0001, 1'b1, 1'b1);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_gap_pct = 14; stall_pct = 61; end
        1: begin send_gap_pct = 61; stall_pct = 14; end
        default: begin send_gap_pct = 0; stall_pct = 0; end
      endcase
      run_segment(16'd1, 16'd1);
      run_segment(16'($urandom_range(2, 6)), 16'hFFFF);
      run_segment(16'($urandom_range(1, 10)), 16'($urandom_range(1, 5)));
      run_segment(16'hFFFF, 16'($urandom_range(1, 3)));
    end

    repeat (10) @(posedge clk);
    $display("Sent %0d sample words in %0d records; %0d peak words matched.",
             words_sent, records_done, matched);
    $display("Separation and limit swept 1 to 65535 under three idle mixes.");
    if (mismatches == 0 && awaited == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
